FILE: rtl/core/blea_pkg.sv
`timescale 1ns / 1ps

package blea_pkg;

  // Address width default and fixed field widths
  localparam int ADDR_BITS_DEF = 48;
  localparam int OUT_W         = 48;
  localparam int X_W           = 16;
  localparam int Y_W           = 16;
  localparam int Z_W           = 11;
  localparam int S_TDATA_W     = 48;   // 43 bits of fields padded to whole bytes
  localparam int M_TDATA_W     = 48;

  localparam int BPE_W     = 5;
  localparam int DIM_W     = 17;
  localparam int LOG2_W    = 3;
  localparam int XB_W      = X_W + BPE_W;       // element column in bytes
  localparam int PITCH_W   = 17;                // row pitch in GOB columns
  localparam int RPG_W     = 15;                // rows of blocks per depth group
  localparam int GROUP_W   = PITCH_W + RPG_W;   // depth group size in GOB columns
  localparam int TY_W      = Y_W + PITCH_W;
  localparam int TZ_W      = Z_W + GROUP_W;
  localparam int SHIFT_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPE      = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_BLK_H    = 3'd3,
    REG_BLK_D    = 3'd4
  } blea_reg_t;

  // Configuration as seen by the datapath, including derived sizes
  typedef struct packed {
    logic [BPE_W-1:0]   bpe;
    logic [LOG2_W-1:0]  bh;
    logic [LOG2_W-1:0]  bd;
    logic [PITCH_W-1:0] pitch_gobs;
    logic [GROUP_W-1:0] group_gobs;
  } blea_cfg_t;

endpackage

FILE: rtl/core/block_linear_element_address.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents (low bit up)
// s_*       in   48     tdata: x_element[15:0], y_row[31:16], z_slice[42:32], zero pad
// m_*       out  48     tdata: byte_offset[47:0]
// cfg_*     in   3+17   cfg_index selects register 0..4, cfg_data holds its value
//
// One item per cycle sustained while m_tready stays high and no config settles;
// four registers in the pipe (input reg, multiply, shift/partial add, sum).
// Reset is synchronous; it restores register defaults and empties the pipe.
// After reset or any config write, s_tready stays low while the derived
// pitch and depth-group size are recomputed.
// A stalled m_tready holds the result; earlier stages keep filling bubbles.
module block_linear_element_address
  import blea_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input coordinates
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // x_element, y_row, z_slice
  // result offsets
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // byte_offset
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  blea_cfg_t        cfg;
  logic             hold;
  logic [OUT_W-1:0] byte_offset;

  blea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .hold      (hold)
  );

  // pad bits above z_slice in s_tdata are ignored
  blea_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hold        (hold),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .x_element   (s_tdata[15:0]),
    .y_row       (s_tdata[31:16]),
    .z_slice     (s_tdata[42:32]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .byte_offset (byte_offset)
  );

  assign m_tdata = byte_offset;

endmodule

FILE: rtl/core/blea_cfg.sv
`timescale 1ns / 1ps

module blea_cfg
  import blea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output blea_cfg_t             cfg,
  output logic                  hold
);

  logic [BPE_W-1:0]   bpe;
  logic [DIM_W-1:0]   width;
  logic [DIM_W-1:0]   height;
  logic [LOG2_W-1:0]  bh;
  logic [LOG2_W-1:0]  bd;
  logic [PITCH_W-1:0] pitch_gobs;
  logic [RPG_W-1:0]   rpg;
  logic [GROUP_W-1:0] group_gobs;
  logic [1:0]         settle;

  logic               wr;
  logic [22:0]        pitch_bytes;
  logic [17:0]        height_up;
  logic [17:0]        blk_lines_m1;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpe    <= BPE_W'(4);
      width  <= DIM_W'(1);
      height <= DIM_W'(1);
      bh     <= LOG2_W'(4);
      bd     <= LOG2_W'(0);
    end else if (wr) begin
      case (cfg_index)
        REG_BPE:    bpe    <= cfg_data[BPE_W-1:0];
        REG_WIDTH:  width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height <= cfg_data[DIM_W-1:0];
        REG_BLK_H:  bh     <= cfg_data[LOG2_W-1:0];
        REG_BLK_D:  bd     <= cfg_data[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // derived sizes: pitch and rows per group are registered, then the group size from them
  assign pitch_bytes  = 23'(width) * 23'(bpe) + 23'd63;
  assign blk_lines_m1 = (18'd8 << bh) - 18'd1;
  assign height_up    = 18'(height) + blk_lines_m1;

  always_ff @(posedge clk) begin
    pitch_gobs <= pitch_bytes[22:6];
    rpg        <= RPG_W'(height_up >> (5'd3 + 5'(bh)));
    group_gobs <= GROUP_W'(pitch_gobs) * GROUP_W'(rpg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'b11;
    end else if (wr) begin
      settle <= 2'b11;
    end else begin
      settle <= {1'b0, settle[1]};
    end
  end

  assign hold = |settle;

  assign cfg.bpe        = bpe;
  assign cfg.bh         = bh;
  assign cfg.bd         = bd;
  assign cfg.pitch_gobs = pitch_gobs;
  assign cfg.group_gobs = group_gobs;

endmodule

FILE: rtl/core/blea_datapath.sv
`timescale 1ns / 1ps

module blea_datapath
  import blea_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  blea_cfg_t        cfg,
  input  logic             hold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [X_W-1:0]   x_element,
  input  logic [Y_W-1:0]   y_row,
  input  logic [Z_W-1:0]   z_slice,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] byte_offset
);

  // stage 1: coordinates
  logic             v1;
  logic [X_W-1:0]   x1;
  logic [Y_W-1:0]   y1;
  logic [Z_W-1:0]   z1;
  // stage 2: products and in-block indexes
  logic             v2;
  logic [XB_W-1:0]  xb2;
  logic [TY_W-1:0]  ty2;
  logic [TZ_W-1:0]  tz2;
  logic [6:0]       ylow2;
  logic [6:0]       zlow2;
  logic [2:0]       ysub2;
  // stage 3: partial sums
  logic                 v3;
  logic [ADDR_BITS-1:0] far3;
  logic [ADDR_BITS-1:0] near3;
  // output
  logic                 vo;
  logic [ADDR_BITS-1:0] sum_o;

  logic en1, en2, en3, eno;
  logic [Y_W-1:0]     yq;
  logic [Z_W-1:0]     zq;
  logic [7:0]         hmask;
  logic [7:0]         dmask;
  logic [SHIFT_W-1:0] sh_blk;
  logic [SHIFT_W-1:0] sh_z;
  logic [8:0]         gob_off;
  logic [TZ_W:0]      rows_sum;

  assign eno      = !vo || out_ready;
  assign en3      = !v3 || eno;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && in_ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (eno) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid && in_ready) begin
      x1 <= x_element;
      y1 <= y_row;
      z1 <= z_slice;
    end
  end

  // row-of-blocks and depth-group indexes
  assign yq    = y1 >> (5'd3 + 5'(cfg.bh));
  assign zq    = z1 >> cfg.bd;
  assign hmask = (8'd1 << cfg.bh) - 8'd1;
  assign dmask = (8'd1 << cfg.bd) - 8'd1;

  always_ff @(posedge clk) begin
    if (en2) begin
      xb2   <= XB_W'(x1) * XB_W'(cfg.bpe);
      ty2   <= TY_W'(yq) * TY_W'(cfg.pitch_gobs);
      tz2   <= TZ_W'(zq) * TZ_W'(cfg.group_gobs);
      ylow2 <= y1[9:3] & hmask[6:0];
      zlow2 <= z1[6:0] & dmask[6:0];
      ysub2 <= y1[2:0];
    end
  end

  // sector swizzle inside one GOB
  assign gob_off  = {xb2[5], ysub2[2:1], xb2[4], ysub2[0], xb2[3:0]};
  assign sh_z     = 5'd9 + 5'(cfg.bh);
  assign sh_blk   = sh_z + 5'(cfg.bd);
  assign rows_sum = (TZ_W+1)'(tz2) + (TZ_W+1)'(ty2);

  always_ff @(posedge clk) begin
    if (en3) begin
      far3  <= ADDR_BITS'(rows_sum) << sh_blk;
      near3 <= (ADDR_BITS'(xb2[XB_W-1:6]) << sh_blk)
             | (ADDR_BITS'(zlow2) << sh_z)
             | (ADDR_BITS'(ylow2) << 9)
             | ADDR_BITS'(gob_off);
    end
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      sum_o <= far3 + near3;
    end
  end

  assign out_valid = vo;

  generate
    if (ADDR_BITS >= OUT_W) begin : g_trunc
      assign byte_offset = sum_o[OUT_W-1:0];
    end else begin : g_ext
      assign byte_offset = {{(OUT_W-ADDR_BITS){1'b0}}, sum_o};
    end
  endgenerate

  a_hold_blocks: assert property (@(posedge clk) disable iff (rst) hold |-> !in_ready)
    else $error("item taken while derived config settles");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted item not in stage 1");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> (v1 && $stable(x1) && $stable(y1) && $stable(z1)))
    else $error("stalled stage 1 lost its item");
  a_to_out: assert property (@(posedge clk) disable iff (rst) (v3 && eno) |=> vo)
    else $error("item dropped between stage 3 and output");

endmodule

FILE: tb/sv/tb_block_linear_element_address.sv
`timescale 1ns / 1ps

module tb_block_linear_element_address;
  import blea_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;    // pipe is four deep, leave slack
  localparam int HOLD_AT      = 400;   // result count that starts the long sink stall
  localparam int HOLD_CYCLES  = 120;
  localparam int SHOW_MAX     = 10;

  // Index that maps to no register; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  // One coordinate in flight and the offset it must produce
  typedef struct {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [Z_W-1:0]   z;
    logic [OUT_W-1:0] offset;
  } coord_offset_t;

  // Register copy plus the queue of offsets still owed by the block
  class offset_scoreboard;
    logic [BPE_W-1:0]  bpe;
    logic [DIM_W-1:0]  width_el;
    logic [DIM_W-1:0]  height_rows;
    logic [LOG2_W-1:0] blk_h;
    logic [LOG2_W-1:0] blk_d;
    coord_offset_t     owed[$];
    int                errors;

    function new();
      bpe         = 5'd4;
      width_el    = 17'd1;
      height_rows = 17'd1;
      blk_h       = 3'd4;
      blk_d       = 3'd0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BPE:    bpe         = val[BPE_W-1:0];
        REG_WIDTH:  width_el    = val[DIM_W-1:0];
        REG_HEIGHT: height_rows = val[DIM_W-1:0];
        REG_BLK_H:  blk_h       = val[LOG2_W-1:0];
        REG_BLK_D:  blk_d       = val[LOG2_W-1:0];
        default: ;
      endcase
    endfunction

    // Byte offset of one element; all products wrap at 64 bits
    function logic [OUT_W-1:0] element_offset(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                              logic [Z_W-1:0] z);
      logic [63:0] xb, pitch, lines, slices, row_bytes, rows_per_group, blk_bytes, sum;
      logic [63:0] y64, z64;
      y64   = 64'(y);
      z64   = 64'(z);
      xb    = 64'(x) * 64'(bpe);
      pitch = (64'(width_el) * 64'(bpe) + 64'd63) & ~64'd63;
      lines  = 64'd8 << blk_h;
      slices = 64'd1 << blk_d;
      row_bytes      = pitch * lines * slices;
      rows_per_group = (64'(height_rows) + lines - 64'd1) >> (32'(blk_h) + 3);
      blk_bytes      = 64'd64 * lines * slices;
      sum = (z64 >> blk_d) * row_bytes * rows_per_group
          + (z64 & (slices - 64'd1)) * 64'd64 * lines
          + (y64 >> (32'(blk_h) + 3)) * row_bytes
          + (xb >> 6) * blk_bytes
          + ((y64 & (lines - 64'd1)) & ~64'd7) * 64'd64
          // sector swizzle inside the GOB
          + ((y64 & 64'd6) << 5) + ((y64 & 64'd1) << 4)
          + ((xb & 64'd32) << 3) + (xb & 64'd15) + ((xb & 64'd16) << 1);
      if (ADDR_BITS_DEF < 64)
        sum = sum & ((64'd1 << ADDR_BITS_DEF) - 64'd1);
      return sum[OUT_W-1:0];
    endfunction

    function void note_coord(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [Z_W-1:0] z);
      coord_offset_t c;
      c.x = x;
      c.y = y;
      c.z = z;
      c.offset = element_offset(x, y, z);
      owed.push_back(c);
    endfunction

    function void check_offset(logic [OUT_W-1:0] got);
      coord_offset_t c;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: byte_offset %h with no coordinate pending", $time, got);
        return;
      end
      c = owed.pop_front();
      if (got !== c.offset) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: x=%0d y=%0d z=%0d byte_offset expected %h got %h",
                   $time, c.x, c.y, c.z, c.offset, got);
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void flag_leftover();
      if (owed.size() != 0) begin
        errors += owed.size();
        $display("%0d byte_offset results never arrived", owed.size());
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;    // x_element, y_row, z_slice, zero pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;         // byte_offset
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  offset_scoreboard sb;
  bit idle_on = 1'b1;   // when clear both sides run without gaps
  int cycles = 0;

  block_linear_element_address dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One register write; valid stays up so writes can go back to back.
  // The caller drops cfg_valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] bpe_v, w_v, h_v, bh_v, bd_v,
                               input bit with_spare);
    write_reg(REG_BPE, bpe_v);
    write_reg(REG_WIDTH, w_v);
    write_reg(REG_HEIGHT, h_v);
    write_reg(REG_BLK_H, bh_v);
    write_reg(REG_BLK_D, bd_v);
    if (with_spare)
      write_reg(REG_SPARE, 17'h0ABCD);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_setting();
    int sizes[6] = '{1, 2, 4, 8, 12, 16};
    logic [CFG_DATA_W-1:0] bpe_v, w_v, h_v, bh_v, bd_v;
    int pick;
    bpe_v = ($urandom_range(0, 9) < 8) ? 17'(sizes[$urandom_range(0, 5)])
                                       : 17'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    w_v = (pick < 5) ? 17'($urandom_range(1, 4096)) :
          (pick < 8) ? 17'($urandom_range(1, 65536)) : 17'($urandom_range(0, 131071));
    pick = $urandom_range(0, 19);
    h_v = (pick == 0) ? 17'd0 :
          (pick < 10) ? 17'($urandom_range(1, 4096)) :
          (pick < 16) ? 17'($urandom_range(1, 65536)) : 17'($urandom_range(0, 131071));
    bh_v = 17'($urandom_range(0, 7));
    bd_v = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 7)) : 17'($urandom_range(0, 2));
    apply_setting(bpe_v, w_v, h_v, bh_v, bd_v, 1'b0);
  endtask

  // Offer one coordinate, after a random gap when idle_on is set, and wait for its transfer
  task automatic send_coord(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic [Z_W-1:0] z);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, z, y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_coord(x, y, z);
  endtask

  task automatic run_random(input int count);
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        x = X_W'($urandom);
        y = Y_W'($urandom);
        z = Z_W'($urandom);
      end else begin
        // near the origin, where the GOB and block terms change fastest
        x = X_W'($urandom_range(0, 255));
        y = Y_W'($urandom_range(0, 255));
        z = Z_W'($urandom_range(0, 7));
      end
      send_coord(x, y, z);
    end
  endtask

  // Drop valid and let every owed result come back before touching registers
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Result sink: random stalls, plus one long hold so the pipe backs up
  initial begin : result_sink
    int stall;
    int results_seen;
    results_seen = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_offset(m_tdata[OUT_W-1:0]);
      results_seen++;
      if (results_seen == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values: 4-byte elements, 16-GOB blocks, one slice deep.
    // Field extremes, then each step of the sector swizzle.
    send_coord(16'd0, 16'd0, 11'd0);
    send_coord(16'hFFFF, 16'hFFFF, 11'h7FF);
    send_coord(16'd1, 16'd0, 11'd0);
    send_coord(16'd4, 16'd0, 11'd0);
    send_coord(16'd8, 16'd0, 11'd0);
    send_coord(16'd16, 16'd0, 11'd0);
    send_coord(16'd0, 16'd1, 11'd0);
    send_coord(16'd0, 16'd2, 11'd0);
    send_coord(16'd0, 16'd7, 11'd0);
    send_coord(16'd0, 16'd8, 11'd0);
    send_coord(16'd0, 16'd127, 11'd0);
    send_coord(16'd0, 16'd128, 11'd0);
    send_coord(16'd0, 16'd0, 11'd1);
    send_coord(16'd3, 16'd5, 11'd2);
    finish_phase();

    // All-ones data: odd 31-byte elements, block codes of seven, products that wrap.
    // A write to an unused index rides along and must change nothing.
    apply_setting(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
    send_coord(16'hFFFF, 16'hFFFF, 11'h7FF);
    send_coord(16'd0, 16'd0, 11'h7FF);
    send_coord(16'd1, 16'd1, 11'd1);
    send_coord(16'hFFFF, 16'd0, 11'd0);
    run_random(100);
    finish_phase();

    // All zero: zero-byte elements, zero width and height
    apply_setting(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b0);
    send_coord(16'hFFFF, 16'hFFFF, 11'h7FF);
    send_coord(16'd12, 16'd9, 11'd3);
    run_random(60);
    finish_phase();

    // Zero height with real elements: the depth group term vanishes
    idle_on = 1'b0;
    apply_setting(17'd2, 17'd100, 17'd0, 17'd6, 17'd6, 1'b0);
    run_random(100);
    finish_phase();

    // Twelve-byte elements straddle sector and GOB boundaries
    idle_on = 1'b1;
    apply_setting(17'd12, 17'd1920, 17'd1080, 17'd4, 17'd0, 1'b0);
    send_coord(16'd1, 16'd0, 11'd0);
    send_coord(16'd5, 16'd3, 11'd0);
    send_coord(16'd6, 16'd0, 11'd0);
    run_random(150);
    finish_phase();

    for (int p = 0; p < 9; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      apply_random_setting();
      run_random(125);
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/blea_pkg.sv
rtl/core/blea_cfg.sv
rtl/core/blea_datapath.sv
rtl/core/block_linear_element_address.sv
tb/sv/tb_block_linear_element_address.sv
